### sv/assert_macros.svh
// Assertion macros shared by the ingest core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### sv/tieug_pkg.sv
// Types, constants and helpers for the text ingest core.
package tieug_pkg;

	localparam int COUNT_BITS = 32;
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [1:0] TOP_LEAD = 2'b11;
	localparam logic [1:0] TOP_CONT = 2'b10;

	localparam logic [1:0] ENDING_LF   = 2'd0;
	localparam logic [1:0] ENDING_CR   = 2'd1;
	localparam logic [1:0] ENDING_CRLF = 2'd2;

	typedef logic [COUNT_BITS-1:0] cnt_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] rune_word;
		logic        rune_valid;
		logic [1:0]  ending;
		logic        is_final;
	} out_item_t;

	// Which of the two result slots are written this cycle
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	// Saturating increment
	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == '1) ? v : cnt_t'(v + 1'b1);
	endfunction

endpackage

### sv/text_ingest_eol_utf8_grouper_core.sv
// Top level: input register, normalizer/grouper and result queue.
// Path: a byte held in the input register passes through the normalizer into the result
// queue, which registers each result before the output; a second result follows it out.
// Throughput: one byte per cycle; results drain one per cycle while result_stall is low,
// from a four-entry queue; the input register holds when under two entries are free.
// Reset (arst_n low, asynchronous) clears counters, pending rune and queue.
module text_ingest_eol_utf8_grouper_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  tieug_pkg::in_item_t   item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output tieug_pkg::out_item_t  result
);
	import tieug_pkg::*;

	logic       valid_s1;
	in_item_t   item_s1;
	logic       room, proc, accept;
	push_t      push;
	out_item_t  first_item, second_item;

	assign proc       = valid_s1 && room;
	assign item_stall = valid_s1 && !room;
	assign accept     = item_valid && !item_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	tieug_norm u_norm (
		.clk         (clk),
		.arst_n      (arst_n),
		.proc        (proc),
		.item        (item_s1),
		.push        (push),
		.first_item  (first_item),
		.second_item (second_item)
	);

	tieug_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.first_item   (first_item),
		.second_item  (second_item),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### sv/tieug_norm.sv
// Line-ending normalization, rune grouping and ending counters.
`include "assert_macros.svh"
module tieug_norm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  proc,
	input  tieug_pkg::in_item_t   item,
	output tieug_pkg::push_t      push,
	output tieug_pkg::out_item_t  first_item,
	output tieug_pkg::out_item_t  second_item
);
	import tieug_pkg::*;

	logic        after_cr_q;
	logic [31:0] rune_q;
	logic [2:0]  pend_cnt_q;
	cnt_t        lf_cnt_q, cr_cnt_q, crlf_cnt_q;

	logic        is_lf, is_cr;
	logic        grp_en, lead, emit;
	logic [7:0]  gb;
	logic        ac_n;
	logic [31:0] rune_n;
	logic [2:0]  cnt_n;
	cnt_t        lf_n, cr_n, crlf_n, cr_f;
	logic [1:0]  ending;

	// CR/LF handling and counter updates
	always_comb begin
		is_lf  = (item.in_byte == BYTE_LF);
		is_cr  = (item.in_byte == BYTE_CR);
		lf_n   = lf_cnt_q;
		cr_n   = cr_cnt_q;
		crlf_n = crlf_cnt_q;
		ac_n   = after_cr_q;
		grp_en = 1'b1;
		gb     = item.in_byte;
		if (is_lf) begin
			if (after_cr_q) begin
				crlf_n = sat_inc(crlf_cnt_q);
				ac_n   = 1'b0;
				grp_en = 1'b0;
			end else begin
				lf_n = sat_inc(lf_cnt_q);
			end
		end else if (is_cr) begin
			if (after_cr_q) begin
				cr_n = sat_inc(cr_cnt_q);
			end
			ac_n = 1'b1;
			gb   = BYTE_LF;
		end else begin
			if (after_cr_q) begin
				cr_n = sat_inc(cr_cnt_q);
			end
			ac_n = 1'b0;
		end
	end

	// Rune grouping
	always_comb begin
		lead   = !gb[7] || (gb[7:6] == TOP_LEAD);
		emit   = 1'b0;
		rune_n = rune_q;
		cnt_n  = pend_cnt_q;
		if (grp_en && lead) begin
			emit   = (pend_cnt_q != 3'd0);
			rune_n = {24'd0, gb};
			cnt_n  = 3'd1;
		end else if (grp_en && (gb[7:6] == TOP_CONT) && (pend_cnt_q != 3'd0)
			&& (pend_cnt_q != 3'd4)) begin
			rune_n = rune_q | ({24'd0, gb} << {pend_cnt_q[1:0], 3'b000});
			cnt_n  = pend_cnt_q + 3'd1;
		end
	end

	// Trailing CR counts as lone CR; the most frequent ending wins on the last byte, ties go to LF
	always_comb begin
		cr_f = ac_n ? sat_inc(cr_n) : cr_n;
		if ((cr_f > lf_n) && (cr_f > crlf_n)) begin
			ending = ENDING_CR;
		end else if ((crlf_n > lf_n) && (crlf_n > cr_f)) begin
			ending = ENDING_CRLF;
		end else begin
			ending = ENDING_LF;
		end
	end

	// Result slots
	always_comb begin
		push.first             = proc && emit;
		push.second            = proc && item.is_last;
		first_item.rune_word   = rune_q;
		first_item.rune_valid  = 1'b1;
		first_item.ending      = ENDING_LF;
		first_item.is_final    = 1'b0;
		second_item.rune_word  = (cnt_n != 3'd0) ? rune_n : 32'd0;
		second_item.rune_valid = (cnt_n != 3'd0);
		second_item.ending     = ending;
		second_item.is_final   = 1'b1;
	end

	// State registers; the last byte returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_cr_q <= 1'b0;
			rune_q     <= 32'd0;
			pend_cnt_q <= 3'd0;
			lf_cnt_q   <= '0;
			cr_cnt_q   <= '0;
			crlf_cnt_q <= '0;
		end else if (proc) begin
			if (item.is_last) begin
				after_cr_q <= 1'b0;
				rune_q     <= 32'd0;
				pend_cnt_q <= 3'd0;
				lf_cnt_q   <= '0;
				cr_cnt_q   <= '0;
				crlf_cnt_q <= '0;
			end else begin
				after_cr_q <= ac_n;
				rune_q     <= rune_n;
				pend_cnt_q <= cnt_n;
				lf_cnt_q   <= lf_n;
				cr_cnt_q   <= cr_n;
				crlf_cnt_q <= crlf_n;
			end
		end
	end

	`ASSERT_CLK(a_pend_max, clk, arst_n, pend_cnt_q <= 3'd4, "pending rune holds more than four bytes")
	`ASSERT_CLK(a_final_clears, clk, arst_n, (proc && item.is_last) |=> (pend_cnt_q == 3'd0 && !after_cr_q && lf_cnt_q == '0), "state not cleared after final byte")
	`ASSERT_CLK(a_emit_pending, clk, arst_n, push.first |-> (pend_cnt_q != 3'd0), "rune emitted with nothing pending")

endmodule

### sv/tieug_outq.sv
// Result queue: up to two writes and one read per cycle.
`include "assert_macros.svh"
module tieug_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tieug_pkg::push_t      push,
	input  tieug_pkg::out_item_t  first_item,
	input  tieug_pkg::out_item_t  second_item,
	output logic                  room,
	output logic                  result_valid,
	input  logic                  result_stall,
	output tieug_pkg::out_item_t  result
);
	import tieug_pkg::*;

	out_item_t               mem [QDEPTH];
	logic [QPTR_BITS-1:0]    wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0]    cnt_q;
	logic [1:0]              n_push;
	logic                    pop;

	assign n_push       = {1'b0, push.first} + {1'b0, push.second};
	assign pop          = result_valid && !result_stall;
	assign result_valid = (cnt_q != '0);
	assign result       = mem[rd_ptr_q];
	assign room         = (cnt_q <= QCNT_BITS'(QDEPTH - 2));

	// Storage writes, first slot ahead of second
	always_ff @(posedge clk) begin
		if (push.first || push.second) begin
			mem[wr_ptr_q] <= push.first ? first_item : second_item;
		end
		if (push.first && push.second) begin
			mem[QPTR_BITS'(wr_ptr_q + 1'b1)] <= second_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= QPTR_BITS'(wr_ptr_q + n_push);
			if (pop) begin
				rd_ptr_q <= QPTR_BITS'(rd_ptr_q + 1'b1);
			end
			cnt_q <= QCNT_BITS'(cnt_q + n_push - {1'b0, pop});
		end
	end

	`ASSERT_CLK(a_cnt_max, clk, arst_n, cnt_q <= QCNT_BITS'(QDEPTH), "queue count above depth")
	`ASSERT_CLK(a_no_overflow, clk, arst_n, (push.first || push.second) |-> ((cnt_q + n_push) <= QDEPTH), "queue overflow")
	`ASSERT_CLK(a_ptr_track, clk, arst_n, (QPTR_BITS'(rd_ptr_q + cnt_q) == wr_ptr_q) || (cnt_q == QCNT_BITS'(QDEPTH)), "pointers disagree with count")

endmodule
